>>> rtl/ppp_pkg.sv
`default_nettype none

package ppp_pkg;

    // Default field widths of the block.
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int ANGLE_BITS_DEFAULT    = 16;

    // The angle is carried as a 32-bit fraction of one turn inside the rotator.
    localparam int TURN_BITS    = 32;
    localparam int CORDIC_STEPS = 24;

    // Rotator word widths: Q2.30 data with headroom, and the residual angle.
    localparam int XYW      = 34;
    localparam int ZW       = TURN_BITS + 1;
    localparam int CS_BITS  = 32;
    localparam int QUAD_BITS = 2;

    // 1/K in Q2.30, so that the rotator output needs no gain correction.
    localparam logic signed [XYW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [TURN_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 2;
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MOVE_FORWARD = 2'd0,
        REG_MOVE_LATERAL = 2'd1,
        REG_TURN_STEP    = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/ppp_cordic_cell.sv
`default_nettype none

module ppp_cordic_cell #(
    parameter int STEP  = 0,
    parameter int PAY_W = 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [ppp_pkg::XYW-1:0]    in_x,
    input  wire logic signed [ppp_pkg::XYW-1:0]    in_y,
    input  wire logic signed [ppp_pkg::ZW-1:0]     in_z,
    input  wire logic        [PAY_W-1:0]           in_pay,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed      [ppp_pkg::XYW-1:0]    out_x,
    output logic signed      [ppp_pkg::XYW-1:0]    out_y,
    output logic signed      [ppp_pkg::ZW-1:0]     out_z,
    output logic             [PAY_W-1:0]           out_pay
);
    import ppp_pkg::*;

    localparam logic signed [ZW-1:0] STEP_ANGLE =
        $signed({{(ZW-TURN_BITS){1'b0}}, ATAN_TURNS[STEP]});

    logic                    valid_reg;
    logic signed [XYW-1:0]   x_reg, y_reg, x_next, y_next, x_sh, y_sh;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic        [PAY_W-1:0] pay_reg;

    // One micro-rotation; both shifts use the incoming x and y.
    always_comb begin
        x_sh = in_x >>> STEP;
        y_sh = in_y >>> STEP;
        if (!in_z[ZW-1]) begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
            z_next = in_z - STEP_ANGLE;
        end else begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
            z_next = in_z + STEP_ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

>>> rtl/ppp_compose.sv
`default_nettype none

module ppp_compose #(
    parameter int POSITION_BITS = ppp_pkg::POSITION_BITS_DEFAULT,
    parameter int ANGLE_BITS    = ppp_pkg::ANGLE_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [ppp_pkg::XYW-1:0]     in_x,
    input  wire logic signed [ppp_pkg::XYW-1:0]     in_y,
    input  wire logic [ppp_pkg::QUAD_BITS-1:0]      in_quad,
    input  wire logic signed [POSITION_BITS-1:0]    in_pos_x,
    input  wire logic signed [POSITION_BITS-1:0]    in_pos_y,
    input  wire logic [ANGLE_BITS-1:0]              in_heading,
    input  wire logic signed [POSITION_BITS-1:0]    move_forward,
    input  wire logic signed [POSITION_BITS-1:0]    move_lateral,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [POSITION_BITS-1:0]         out_x,
    output logic signed [POSITION_BITS-1:0]         out_y,
    output logic [ANGLE_BITS-1:0]                   out_heading
);
    import ppp_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int LO = PB / 2;             // low part of the motion step, unsigned
    localparam int HP = PB - LO + CS_BITS;  // high partial product
    localparam int HS = HP + 1;
    localparam int LP = LO + 1 + CS_BITS;   // low partial product
    localparam int LS = LP + 1;
    localparam int PW = PB + CS_BITS + 2;   // full dot product plus rounding
    localparam int DW = PW - 30;            // delta after the Q2.30 scale
    localparam int SW = DW + 1;

    localparam logic signed [PW-1:0] ROUND_HALF = $signed({{(PW-30){1'b0}}, 1'b1, 29'b0});
    localparam logic signed [PB-1:0] POS_MAX = $signed({1'b0, {(PB-1){1'b1}}});
    localparam logic signed [PB-1:0] POS_MIN = $signed({1'b1, {(PB-1){1'b0}}});

    logic ready_a, ready_b, ready_c, ready_d;
    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;

    // Quadrant fold and partial products.
    logic signed [CS_BITS-1:0] cx, cy, cos_v, sin_v, nsin_v;
    logic signed [PB-LO:0]     f_hi, l_hi;
    logic signed [LO:0]        f_lo, l_lo;

    logic signed [HP-1:0] fhc_reg, lhns_reg, fhs_reg, lhc_reg;
    logic signed [LP-1:0] flc_reg, llns_reg, fls_reg, llc_reg;
    logic signed [PB-1:0] px_a_reg, py_a_reg, px_b_reg, py_b_reg, px_c_reg, py_c_reg;
    logic [ANGLE_BITS-1:0] hd_a_reg, hd_b_reg, hd_c_reg, hd_d_reg;

    logic signed [HS-1:0] hi_x_reg, hi_y_reg;
    logic signed [LS-1:0] lo_x_reg, lo_y_reg;
    logic signed [PW-1:0] num_x, num_y;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [PB-1:0] x_next, y_next, x_reg, y_reg;

    always_comb begin
        cx = in_x[CS_BITS-1:0];
        cy = in_y[CS_BITS-1:0];
        unique case (in_quad)
            2'd0: begin cos_v = cx;  sin_v = cy;  end
            2'd1: begin cos_v = -cy; sin_v = cx;  end
            2'd2: begin cos_v = -cx; sin_v = -cy; end
            2'd3: begin cos_v = cy;  sin_v = -cx; end
            default: begin cos_v = cx; sin_v = cy; end
        endcase
        nsin_v = -sin_v;
        f_hi = $signed({move_forward[PB-1], move_forward[PB-1:LO]});
        l_hi = $signed({move_lateral[PB-1], move_lateral[PB-1:LO]});
        f_lo = $signed({1'b0, move_forward[LO-1:0]});
        l_lo = $signed({1'b0, move_lateral[LO-1:0]});
    end

    // The step round((F*c + L*k) / 2^30) is exact: F = f_hi*2^LO + f_lo.
    always_comb begin
        num_x = (PW'(hi_x_reg) <<< LO) + PW'(lo_x_reg) + ROUND_HALF;
        num_y = (PW'(hi_y_reg) <<< LO) + PW'(lo_y_reg) + ROUND_HALF;
        sum_x = SW'(px_c_reg) + SW'(dx_reg);
        sum_y = SW'(py_c_reg) + SW'(dy_reg);
        if (sum_x > SW'(POS_MAX)) begin
            x_next = POS_MAX;
        end else if (sum_x < SW'(POS_MIN)) begin
            x_next = POS_MIN;
        end else begin
            x_next = sum_x[PB-1:0];
        end
        if (sum_y > SW'(POS_MAX)) begin
            y_next = POS_MAX;
        end else if (sum_y < SW'(POS_MIN)) begin
            y_next = POS_MIN;
        end else begin
            y_next = sum_y[PB-1:0];
        end
    end

    assign ready_d  = !valid_d_reg || out_ready;
    assign ready_c  = !valid_c_reg || ready_d;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_c) begin
                valid_c_reg <= valid_b_reg;
            end
            if (ready_d) begin
                valid_d_reg <= valid_c_reg;
            end
        end

        if (ready_a && in_valid) begin
            fhc_reg  <= HP'(f_hi) * HP'(cos_v);
            lhns_reg <= HP'(l_hi) * HP'(nsin_v);
            fhs_reg  <= HP'(f_hi) * HP'(sin_v);
            lhc_reg  <= HP'(l_hi) * HP'(cos_v);
            flc_reg  <= LP'(f_lo) * LP'(cos_v);
            llns_reg <= LP'(l_lo) * LP'(nsin_v);
            fls_reg  <= LP'(f_lo) * LP'(sin_v);
            llc_reg  <= LP'(l_lo) * LP'(cos_v);
            px_a_reg <= in_pos_x;
            py_a_reg <= in_pos_y;
            hd_a_reg <= in_heading;
        end
        if (ready_b && valid_a_reg) begin
            hi_x_reg <= HS'(fhc_reg) + HS'(lhns_reg);
            hi_y_reg <= HS'(fhs_reg) + HS'(lhc_reg);
            lo_x_reg <= LS'(flc_reg) + LS'(llns_reg);
            lo_y_reg <= LS'(fls_reg) + LS'(llc_reg);
            px_b_reg <= px_a_reg;
            py_b_reg <= py_a_reg;
            hd_b_reg <= hd_a_reg;
        end
        if (ready_c && valid_b_reg) begin
            dx_reg   <= num_x[PW-1:30];
            dy_reg   <= num_y[PW-1:30];
            px_c_reg <= px_b_reg;
            py_c_reg <= py_b_reg;
            hd_c_reg <= hd_b_reg;
        end
        if (ready_d && valid_c_reg) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            hd_d_reg <= hd_c_reg;
        end
    end

    assign out_valid   = valid_d_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_heading = hd_d_reg;

endmodule

`default_nettype wire

>>> rtl/particle_pose_prediction_unit.sv
// Particle pose prediction: moves each particle pose by one odometry step.
//
// Input stream (s_*): one particle per transfer, x and y in signed Q16.16 and
// a binary-angle heading. Result stream (m_*): the updated pose in the same
// layout. Each particle gives exactly one result, in input order.
//
// The motion step is held in three registers written through the cfg_* port
// (0 forward step, 1 lateral step, 2 turn step); write them between batches,
// when no particle is in flight.
//
// From an input transfer to m_tvalid a particle passes 24 rotator cells of
// the sine/cosine chain, then a multiply, a sum, a round and a saturating
// add stage. One particle is taken every cycle while m_tready stays high;
// every stage can take a new particle while handing the last one on.
//
// Every stage holds its item while the one after it is full, so a stalled
// receiver stops the pipe from the output end backwards and bubbles are
// squeezed out. Reset clears the motion registers to zero and empties the pipe.
`default_nettype none

module particle_pose_prediction_unit #(
    parameter int POSITION_BITS = ppp_pkg::POSITION_BITS_DEFAULT,
    parameter int ANGLE_BITS    = ppp_pkg::ANGLE_BITS_DEFAULT,
    localparam int CFG_W = (POSITION_BITS > ANGLE_BITS) ? POSITION_BITS : ANGLE_BITS,
    localparam int DATA_W = ((2 * POSITION_BITS + ANGLE_BITS + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ppp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]                   cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [DATA_W-1:0]                  s_tdata,  // pos_x, pos_y, heading
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [DATA_W-1:0]                       m_tdata   // new_x, new_y, new_heading
);
    import ppp_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int AB    = ANGLE_BITS;
    localparam int PAY_W = QUAD_BITS + AB + 2 * PB;

    logic signed [PB-1:0] move_forward_reg, move_lateral_reg;
    logic [AB-1:0]        turn_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_forward_reg <= '0;
            move_lateral_reg <= '0;
            turn_step_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MOVE_FORWARD: move_forward_reg <= $signed(cfg_wr_data[PB-1:0]);
                REG_MOVE_LATERAL: move_lateral_reg <= $signed(cfg_wr_data[PB-1:0]);
                REG_TURN_STEP:    turn_step_reg    <= cfg_wr_data[AB-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking and nearest-quadrant reduction of the heading.
    logic signed [PB-1:0]    in_px, in_py;
    logic [AB-1:0]           in_hd, in_new_hd;
    logic [TURN_BITS-1:0]    turn_a, turn_r, turn_round;
    logic [QUAD_BITS-1:0]    in_quad;

    always_comb begin
        in_px      = $signed(s_tdata[PB-1:0]);
        in_py      = $signed(s_tdata[2*PB-1:PB]);
        in_hd      = s_tdata[2*PB+AB-1:2*PB];
        in_new_hd  = in_hd + turn_step_reg;
        turn_a     = {in_hd, {(TURN_BITS-AB){1'b0}}};
        turn_round = turn_a + {3'b001, {(TURN_BITS-3){1'b0}}};
        in_quad    = turn_round[TURN_BITS-1:TURN_BITS-QUAD_BITS];
        turn_r     = turn_a - {in_quad, {(TURN_BITS-QUAD_BITS){1'b0}}};
    end

    logic                  cv_w  [CORDIC_STEPS+1];
    logic                  cr_w  [CORDIC_STEPS+1];
    logic signed [XYW-1:0] cx_w  [CORDIC_STEPS+1];
    logic signed [XYW-1:0] cy_w  [CORDIC_STEPS+1];
    logic signed [ZW-1:0]  cz_w  [CORDIC_STEPS+1];
    logic [PAY_W-1:0]      pay_w [CORDIC_STEPS+1];

    assign cv_w[0]  = s_tvalid;
    assign s_tready = cr_w[0];
    assign cx_w[0]  = CORDIC_INV_GAIN;
    assign cy_w[0]  = '0;
    assign cz_w[0]  = $signed({turn_r[TURN_BITS-1], turn_r});
    assign pay_w[0] = {in_quad, in_new_hd, in_py, in_px};

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        ppp_cordic_cell #(
            .STEP  (i),
            .PAY_W (PAY_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv_w[i]),
            .in_ready  (cr_w[i]),
            .in_x      (cx_w[i]),
            .in_y      (cy_w[i]),
            .in_z      (cz_w[i]),
            .in_pay    (pay_w[i]),
            .out_valid (cv_w[i+1]),
            .out_ready (cr_w[i+1]),
            .out_x     (cx_w[i+1]),
            .out_y     (cy_w[i+1]),
            .out_z     (cz_w[i+1]),
            .out_pay   (pay_w[i+1])
        );
    end

    logic signed [PB-1:0] res_x, res_y;
    logic [AB-1:0]        res_hd;
    logic [PAY_W-1:0]     pay_last;

    assign pay_last = pay_w[CORDIC_STEPS];

    // The residual angle left in the last cell is not needed.
    ppp_compose #(
        .POSITION_BITS (PB),
        .ANGLE_BITS    (AB)
    ) u_compose (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (cv_w[CORDIC_STEPS]),
        .in_ready     (cr_w[CORDIC_STEPS]),
        .in_x         (cx_w[CORDIC_STEPS]),
        .in_y         (cy_w[CORDIC_STEPS]),
        .in_quad      (pay_last[PAY_W-1:PAY_W-QUAD_BITS]),
        .in_pos_x     ($signed(pay_last[PB-1:0])),
        .in_pos_y     ($signed(pay_last[2*PB-1:PB])),
        .in_heading   (pay_last[2*PB+AB-1:2*PB]),
        .move_forward (move_forward_reg),
        .move_lateral (move_lateral_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_x        (res_x),
        .out_y        (res_y),
        .out_heading  (res_hd)
    );

    assign m_tdata = DATA_W'({res_hd, res_y, res_x});

endmodule

`default_nettype wire

>>> verif/particle_pose_prediction_unit_tb.sv
`default_nettype none

module particle_pose_prediction_unit_tb;

    import ppp_pkg::*;

    localparam int POS_W  = POSITION_BITS_DEFAULT;
    localparam int ANG_W  = ANGLE_BITS_DEFAULT;
    localparam int REG_W  = (POS_W > ANG_W) ? POS_W : ANG_W;
    localparam int DATA_W = ((2 * POS_W + ANG_W + 7) / 8) * 8;

    localparam int  ROT_STEPS    = 24;
    localparam longint INV_GAIN_Q30 = 64'sd652032874;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam longint POS_MAX      = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN      = -POS_MAX - 1;

    // An index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [POS_W-1:0] XMAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] XMIN = 32'sh8000_0000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_STEP [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANG_W-1:0]        hdg;
    } pose_t;

    class pose_scoreboard;
        logic signed [POS_W-1:0] fwd_step;
        logic signed [POS_W-1:0] lat_step;
        logic [ANG_W-1:0]        turn;
        pose_t                   expected_poses[$];
        int                      errors;

        function new();
            fwd_step = '0;
            lat_step = '0;
            turn     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                REG_MOVE_FORWARD: fwd_step = val[POS_W-1:0];
                REG_MOVE_LATERAL: lat_step = val[POS_W-1:0];
                REG_TURN_STEP:    turn     = val[ANG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_MAX) return POS_MAX;
            if (v < POS_MIN) return POS_MIN;
            return v;
        endfunction

        // Sine and cosine in Q2.30 by a vectoring-free rotation of the residual
        // angle, then a fix-up by whole quarter turns.
        function pose_t moved_pose(pose_t p);
            logic [31:0] ang;
            logic [31:0] biased;
            logic [1:0]  quad;
            logic [31:0] resid;
            longint      z, cx, cy, xs, ys, c, s, f, l, dx, dy;
            pose_t       r;
            ang    = 32'(p.hdg) << (32 - ANG_W);
            biased = ang + 32'h2000_0000;
            quad   = biased[31:30];
            resid  = ang - {quad, 30'd0};
            z      = longint'($signed(resid));
            cx     = INV_GAIN_Q30;
            cy     = 0;
            for (int i = 0; i < ROT_STEPS; i++) begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (z >= 0) begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z  = z - longint'(ATAN_STEP[i]);
                end else begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z  = z + longint'(ATAN_STEP[i]);
                end
            end
            case (quad)
                2'd1: begin c = -cy; s = cx;  end
                2'd2: begin c = -cx; s = -cy; end
                2'd3: begin c = cy;  s = -cx; end
                default: begin c = cx; s = cy; end
            endcase
            f  = longint'(fwd_step);
            l  = longint'(lat_step);
            // Half-up rounding of the exact Q30 products.
            dx = (f * c - l * s + HALF_Q30) >>> 30;
            dy = (f * s + l * c + HALF_Q30) >>> 30;
            r.x   = POS_W'(clamp_pos(longint'(p.x) + dx));
            r.y   = POS_W'(clamp_pos(longint'(p.y) + dy));
            r.hdg = p.hdg + turn;
            return r;
        endfunction

        function void note_particle(pose_t p);
            expected_poses.push_back(moved_pose(p));
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(pose_t got);
            pose_t want;
            if (expected_poses.size() == 0) begin
                report("unrequested result (x)", 64'(got.x), 64'd0);
            end else begin
                want = expected_poses.pop_front();
                if (got.x !== want.x)
                    report("new_x", 64'(got.x), 64'(want.x));
                if (got.y !== want.y)
                    report("new_y", 64'(got.y), 64'(want.y));
                if (got.hdg !== want.hdg)
                    report("new_heading", 64'(got.hdg), 64'(want.hdg));
            end
        endtask
    endclass

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr    = '0;
    logic [REG_W-1:0]         cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [DATA_W-1:0]        s_tdata     = '0;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [DATA_W-1:0]        m_tdata;

    pose_scoreboard sb = new();
    int             burst_left = 0;
    int             cycle_count = 0;
    int             rx_tick = 0;
    int             rx_mode = 0;

    particle_pose_prediction_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] pack_pose(pose_t p);
        logic [DATA_W-1:0] d;
        d = '0;
        d[POS_W-1:0]                   = p.x;
        d[2*POS_W-1:POS_W]             = p.y;
        d[2*POS_W+ANG_W-1:2*POS_W]     = p.hdg;
        return d;
    endfunction

    function automatic pose_t unpack_pose(logic [DATA_W-1:0] d);
        pose_t p;
        p.x   = d[POS_W-1:0];
        p.y   = d[2*POS_W-1:POS_W];
        p.hdg = d[2*POS_W+ANG_W-1:2*POS_W];
        return p;
    endfunction

    function automatic pose_t make_pose(logic signed [POS_W-1:0] x,
                                        logic signed [POS_W-1:0] y,
                                        logic [ANG_W-1:0] h);
        pose_t p;
        p.x   = x;
        p.y   = y;
        p.hdg = h;
        return p;
    endfunction

    function automatic logic signed [POS_W-1:0] random_position();
        case ($urandom_range(0, 7))
            0: return XMAX - POS_W'($urandom_range(0, 1 << 20));
            1: return XMIN + POS_W'($urandom_range(0, 1 << 20));
            2: return POS_W'($signed($urandom_range(0, 1 << 22)) - (1 <<< 21));
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic pose_t random_particle();
        logic [ANG_W-1:0] h;
        h = ANG_W'($urandom);
        // Headings close to the quadrant split points stress the quarter-turn fix-up.
        if ($urandom_range(0, 9) == 0)
            h = ANG_W'({2'($urandom), 1'b1, {(ANG_W-3){1'b0}}}
                       + ANG_W'($urandom_range(0, 4)) - 2);
        return make_pose(random_position(), random_position(), h);
    endfunction

    // Register writes go out on consecutive cycles with the enable held high.
    task automatic write_regs(logic [CFG_ADDR_BITS-1:0] idx[$], logic [REG_W-1:0] val[$]);
        for (int k = 0; k < idx.size(); k++) begin
            if (k == 0)
                cfg_wr_en <= 1'b1;
            cfg_addr    <= idx[k];
            cfg_wr_data <= val[k];
            @(posedge aclk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_motion(logic signed [POS_W-1:0] fwd, logic signed [POS_W-1:0] lat,
                              logic [REG_W-1:0] turn_word);
        write_regs('{REG_MOVE_FORWARD, REG_MOVE_LATERAL, REG_TURN_STEP},
                   '{REG_W'(fwd), REG_W'(lat), turn_word});
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic send_particle(pose_t p);
        s_tdata <= pack_pose(p);
        if (!s_tvalid)
            s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 40);
        end
    endtask

    task automatic send_plan(pose_t plan[$]);
        foreach (plan[k])
            send_particle(plan[k]);
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_particle(unpack_pose(s_tdata));
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(unpack_pose(m_tdata));
    end

    // The receiver moves among randomly chosen stall patterns, one of which never stalls.
    always @(posedge aclk) begin
        rx_tick = rx_tick + 1;
        if (rx_tick % 300 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_tick % 5 != 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        pose_t plan[$];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 10);

        // Reset values of the registers: no motion, no turn.
        send_plan('{make_pose(XMAX, XMIN, 16'h1234), make_pose(XMIN, XMAX, 16'hFFFF),
                    make_pose(32'sd0, -32'sd1, 16'h0000)});
        wait_drained();

        // Largest forward step, most negative lateral step; the turn word carries
        // junk above the angle width, and its low part 16'hFFFF turns every heading back by one.
        set_motion(XMAX, XMIN, 32'hABCD_FFFF);
        send_plan('{make_pose(32'sd0, 32'sd0, 16'h0000), make_pose(32'sd0, 32'sd0, 16'h4000),
                    make_pose(32'sd0, 32'sd0, 16'h8000), make_pose(32'sd0, 32'sd0, 16'hC000),
                    make_pose(XMAX, XMAX, 16'h0000), make_pose(XMIN, XMIN, 16'h8000),
                    make_pose(XMAX, XMIN, 16'h2000), make_pose(XMIN, XMAX, 16'h1FFF),
                    make_pose(-32'sd1, 32'sd1, 16'hFFFF),
                    make_pose(32'sh0001_0000, -32'sh0001_0000, 16'h6000)});
        wait_drained();

        set_motion(XMIN, XMAX, 32'h0000_8001);
        send_plan('{make_pose(XMAX, XMAX, 16'h4000), make_pose(XMIN, XMIN, 16'hC000),
                    make_pose(32'sd0, 32'sd0, 16'hE000), make_pose(XMAX, XMIN, 16'hA000),
                    make_pose(32'sd0, 32'sd0, 16'h0001), make_pose(XMIN, 32'sd0, 16'hFFFF)});
        wait_drained();

        // A write to an index with no register must leave the motion step alone.
        write_regs('{REG_UNUSED}, '{REG_W'($urandom)});
        send_plan('{make_pose(32'sd12345, -32'sd777, 16'h3A5C),
                    make_pose(XMAX, XMIN, 16'h5FFF)});

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: set_motion(POS_W'($signed($urandom_range(0, 1 << 18)) - (1 <<< 17)),
                              POS_W'($signed($urandom_range(0, 1 << 16)) - (1 <<< 15)),
                              REG_W'($urandom_range(0, 2000)));
                1: set_motion(POS_W'($urandom), POS_W'($urandom), REG_W'($urandom));
                2: set_motion(XMAX, XMAX, REG_W'(0));
                3: set_motion(XMIN, 32'sd0, REG_W'($urandom));
                default: set_motion(POS_W'($urandom), POS_W'($urandom), REG_W'($urandom));
            endcase
            plan.delete();
            repeat (210)
                plan.push_back(random_particle());
            send_plan(plan);
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/ppp_pkg.sv
rtl/ppp_cordic_cell.sv
rtl/ppp_compose.sv
rtl/particle_pose_prediction_unit.sv
verif/particle_pose_prediction_unit_tb.sv
